### sv/msp_pkg.sv
package msp_pkg;

   // field widths of the channels
   localparam int CMD_W    = 1;
   localparam int NODE_W   = 6;
   localparam int WEIGHT_W = 12;
   localparam int DIST_W   = 17;

   // default node count of the matrix
   localparam int NODES_DEFAULT = 16;

   // distance constants
   localparam logic [DIST_W-1:0] INF_DIST    = DIST_W'(100000);
   localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(1000);

   // item commands
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_COL,
      ST_DRAIN,
      ST_FIN_RD,
      ST_FIN_WAIT
   } state_type;

   // status from the engine to the top level
   typedef struct packed {
      logic clearing;
      logic busy;
   } status_type;

endpackage

### sv/msp_if.sv
interface msp_req_if import msp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [NODE_W-1:0]   row_node;
   logic [NODE_W-1:0]   col_node;
   logic [WEIGHT_W-1:0] edge_weight;
   logic [NODE_W-1:0]   start_node;
   logic [NODE_W-1:0]   end_node;

   modport source (output valid, cmd, row_node, col_node, edge_weight, start_node,
                   end_node, input ready);
   modport sink (input valid, cmd, row_node, col_node, edge_weight, start_node,
                 end_node, output ready);
endinterface

interface msp_rsp_if import msp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink (input valid, distance, output ready);
endinterface

### sv/matrix_shortest_path_unit.sv
// load item: no result; the next item may follow in the next cycle
// query item: the result comes from a relaxation sweep of N rounds over all N rows,
//   one edge-memory read per cycle while a row's columns are scanned; no new item
//   is taken until the result has been written to the output register
// the result waits in an output register; a new item is taken meanwhile
// reset: synchronous, clears the edge matrix in a pass over all N*N entries during
//   which no item is accepted; the no-route limit returns to 1000
module matrix_shortest_path_unit import msp_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [DIST_W-1:0] csr_wdata,
   msp_req_if.sink           req,
   msp_rsp_if.source         rsp
);

   logic [DIST_W-1:0] limit_ff, limit_in;
   status_type        status;

   // no-route limit register
   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // relaxation engine with the edge and distance memories
   msp_engine #(.NODES(NODES)) u_engine (
      .clock  (clock),
      .reset  (reset),
      .limit  (limit_ff),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

   // no item is taken while the matrix is being cleared
   assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req.ready)
      else $error("item accepted during clearing pass");

   // a query in progress blocks the input
   assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req.ready)
      else $error("item accepted during a query");

   // a reported distance is zero, or lies below the limit and at most at the no-route value
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.distance == '0) ||
                    ((rsp.distance < limit_ff) && (rsp.distance <= INF_DIST)))
      else $error("distance out of range");

   // clearing pass starts right after reset
   assert property (@(posedge clock)
      $fell(reset) |-> status.clearing)
      else $error("no clearing pass after reset");

endmodule

### sv/msp_ram.sv
module msp_ram import msp_pkg::*; #(
   parameter int WIDTH = DIST_W,
   parameter int DEPTH = NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### sv/msp_engine.sv
module msp_engine import msp_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [DIST_W-1:0] limit,
   output status_type        status,
   msp_req_if.sink           req,
   msp_rsp_if.source         rsp
);

   localparam int NW = $clog2(NODES);
   localparam int AW = $clog2(NODES * NODES);
   localparam logic [NW-1:0]   LAST_NODE = NW'(NODES - 1);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(NODES * NODES - 1);
   localparam logic [NODE_W:0] NODES_W   = (NODE_W + 1)'(NODES);

   state_type state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]     row_ff, row_in;
   logic [NW-1:0]     rowcnt_ff, rowcnt_in;
   logic [NW-1:0]     round_ff, round_in;
   logic [NW-1:0]     col_ff, col_in;
   logic              p_valid_ff, p_valid_in;
   logic [NW-1:0]     p_col_ff, p_col_in;
   logic [DIST_W-1:0] drow_ff, drow_in;
   logic [NODE_W-1:0] start_ff, start_in;
   logic [NODE_W-1:0] end_ff, end_in;
   logic              start_ok_ff, start_ok_in;
   logic              end_ok_ff, end_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   logic                e_we, e_re;
   logic [AW-1:0]       e_waddr, e_raddr;
   logic [WEIGHT_W-1:0] e_wdata, e_rdata;
   logic                d_we, d_re;
   logic [NW-1:0]       d_waddr, d_raddr;
   logic [DIST_W-1:0]   d_wdata, d_rdata;

   logic                accept;
   logic                load_ok;
   logic [DIST_W:0]     cand;
   logic                upd;

   // edge weights, one row after another
   msp_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODES * NODES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_en   (e_re),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   // distance vector
   msp_ram #(.WIDTH(DIST_W), .DEPTH(NODES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_en   (d_re),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   assign req.ready    = (state_ff == ST_IDLE);
   assign accept       = req.valid && req.ready;
   assign load_ok      = ({1'b0, req.row_node} < NODES_W) && ({1'b0, req.col_node} < NODES_W);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.distance = rsp_dist_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.busy     = (state_ff != ST_CLEAR) && (state_ff != ST_IDLE);

   // relaxation of one edge: candidate from the current row's distance
   assign cand = {1'b0, drow_ff} + (DIST_W + 1)'(e_rdata);
   assign upd  = p_valid_ff && (e_rdata != '0) && (cand < {1'b0, d_rdata});

   // sequencer, next state and memory controls
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      row_in       = row_ff;
      rowcnt_in    = rowcnt_ff;
      round_in     = round_ff;
      col_in       = col_ff;
      p_valid_in   = 1'b0;
      p_col_in     = col_ff;
      drow_in      = drow_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      start_ok_in  = start_ok_ff;
      end_ok_in    = end_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_dist_in  = rsp_dist_ff;

      e_we    = 1'b0;
      e_waddr = AW'(int'(req.row_node) * NODES + int'(req.col_node));
      e_wdata = req.edge_weight;
      e_re    = 1'b0;
      e_raddr = AW'(int'(row_ff) * NODES + int'(col_ff));
      d_we    = upd;
      d_waddr = p_col_ff;
      d_wdata = cand[DIST_W-1:0];
      d_re    = 1'b0;
      d_raddr = col_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            e_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.cmd == CMD_LOAD) begin
                  e_we = load_ok;
               end else begin
                  start_in    = req.start_node;
                  end_in      = req.end_node;
                  start_ok_in = ({1'b0, req.start_node} < NODES_W);
                  end_ok_in   = ({1'b0, req.end_node} < NODES_W);
                  col_in      = '0;
                  state_in    = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            // every distance to the no-route value, the start node to zero
            d_we    = 1'b1;
            d_waddr = col_ff;
            d_wdata = (start_ok_ff && (col_ff == start_ff[NW-1:0])) ? '0 : INF_DIST;
            col_in  = col_ff + 1'b1;
            if (col_ff == LAST_NODE) begin
               row_in    = start_ff[NW-1:0];
               rowcnt_in = '0;
               round_in  = '0;
               state_in  = start_ok_ff ? ST_ROW_RD : ST_FIN_RD;
            end
         end
         ST_ROW_RD: begin
            d_re     = 1'b1;
            d_raddr  = row_ff;
            state_in = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            drow_in  = d_rdata;
            col_in   = '0;
            state_in = ST_COL;
         end
         ST_COL: begin
            // issue the reads of one column, update the previous one
            e_re       = 1'b1;
            d_re       = 1'b1;
            p_valid_in = 1'b1;
            col_in     = col_ff + 1'b1;
            if (col_ff == LAST_NODE) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            row_in    = (row_ff == LAST_NODE) ? '0 : row_ff + 1'b1;
            rowcnt_in = rowcnt_ff + 1'b1;
            state_in  = ST_ROW_RD;
            if (rowcnt_ff == LAST_NODE) begin
               rowcnt_in = '0;
               round_in  = round_ff + 1'b1;
               if (round_ff == LAST_NODE) begin
                  state_in = ST_FIN_RD;
               end
            end
         end
         ST_FIN_RD: begin
            d_re     = 1'b1;
            d_raddr  = end_ff[NW-1:0];
            state_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = (end_ok_ff && (d_rdata < limit)) ? d_rdata : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and counter registers
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      rowcnt_ff   <= rowcnt_in;
      round_ff    <= round_in;
      col_ff      <= col_in;
      p_col_ff    <= p_col_in;
      drow_ff     <= drow_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      start_ok_ff <= start_ok_in;
      end_ok_ff   <= end_ok_in;
      rsp_dist_ff <= rsp_dist_in;
   end

endmodule

### tb/matrix_shortest_path_unit_tb.sv
`timescale 1ns / 1ps

module matrix_shortest_path_unit_tb;
   import msp_pkg::*;

   localparam int NODES          = NODES_DEFAULT;
   localparam int QUERY_CYCLES   = NODES * NODES * (NODES + 3) + NODES + 3;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 2 * QUERY_CYCLES + 400;
   localparam int WATCHDOG_LIMIT = 8 * QUERY_CYCLES;
   localparam logic [DIST_W-1:0] LIMIT_ALL_ONES = '1;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [NODE_W-1:0]   row_node;
      logic [NODE_W-1:0]   col_node;
      logic [WEIGHT_W-1:0] edge_weight;
      logic [NODE_W-1:0]   start_node;
      logic [NODE_W-1:0]   end_node;
   } path_item_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [DIST_W-1:0] csr_wdata;

   msp_req_if req_bus ();
   msp_rsp_if rsp_bus ();

   matrix_shortest_path_unit #(
      .NODES(NODES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req      (req_bus),
      .rsp      (rsp_bus)
   );

   // predictor state
   logic [WEIGHT_W-1:0] weight_table [NODES][NODES];
   logic [DIST_W-1:0]   route_limit;
   logic [DIST_W-1:0]   expected_distances [$];

   // run bookkeeping
   int  fail_count;
   int  loads_applied;
   int  loads_ignored;
   int  queries_sent;
   int  distances_checked;
   int  limits_written;
   int  quiet_cycles;
   bit  idle_on;
   bit  rsp_hold_req;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // shortest distance from src to dst under the current weights and limit
   function automatic logic [DIST_W-1:0] shortest_distance(input logic [NODE_W-1:0] src,
                                                          input logic [NODE_W-1:0] dst);
      logic [DIST_W-1:0] dist_vec [NODES];
      logic [DIST_W:0]   cand;
      logic [WEIGHT_W-1:0] w;
      int row;
      for (int i = 0; i < NODES; i++) dist_vec[i] = INF_DIST;
      if (src < NODES) begin
         dist_vec[src] = '0;
         for (int r = 0; r < NODES; r++) begin
            for (int i = 0; i < NODES; i++) begin
               row = (i + int'(src)) % NODES;
               for (int j = 0; j < NODES; j++) begin
                  w    = weight_table[row][j];
                  cand = {1'b0, dist_vec[row]} + (DIST_W + 1)'(w);
                  if (w != '0 && cand < {1'b0, dist_vec[j]}) dist_vec[j] = cand[DIST_W-1:0];
               end
            end
         end
      end
      if (dst >= NODES) return '0;
      if (dist_vec[dst] >= route_limit) return '0;
      return dist_vec[dst];
   endfunction

   // update the weight table or queue the expected distance for an accepted item
   function automatic void apply_item(input path_item_type it);
      if (it.cmd == CMD_LOAD) begin
         if (it.row_node < NODES && it.col_node < NODES) begin
            weight_table[it.row_node][it.col_node] = it.edge_weight;
            loads_applied++;
         end else begin
            loads_ignored++;
         end
      end else begin
         expected_distances.push_back(shortest_distance(it.start_node, it.end_node));
         queries_sent++;
      end
   endfunction

   // item with every field random
   function automatic path_item_type random_fill();
      path_item_type it;
      it.cmd         = CMD_W'($urandom());
      it.row_node    = NODE_W'($urandom());
      it.col_node    = NODE_W'($urandom());
      it.edge_weight = WEIGHT_W'($urandom());
      it.start_node  = NODE_W'($urandom());
      it.end_node    = NODE_W'($urandom());
      return it;
   endfunction

   function automatic path_item_type load_item(input int row,
                                               input int col,
                                               input int weight);
      path_item_type it;
      it             = random_fill();
      it.cmd         = CMD_LOAD;
      it.row_node    = NODE_W'(row);
      it.col_node    = NODE_W'(col);
      it.edge_weight = WEIGHT_W'(weight);
      return it;
   endfunction

   function automatic path_item_type query_item(input int src,
                                                input int dst);
      path_item_type it;
      it            = random_fill();
      it.cmd        = CMD_QUERY;
      it.start_node = NODE_W'(src);
      it.end_node   = NODE_W'(dst);
      return it;
   endfunction

   // mostly loads into the matrix with short weights, some queries, a little noise
   function automatic path_item_type random_graph_item();
      path_item_type it;
      int pick;
      it   = random_fill();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         it.cmd = CMD_QUERY;
         if ($urandom_range(0, 99) < 92) it.start_node = NODE_W'($urandom_range(0, NODES - 1));
         if ($urandom_range(0, 99) < 92) it.end_node = NODE_W'($urandom_range(0, NODES - 1));
      end else begin
         it.cmd = CMD_LOAD;
         if ($urandom_range(0, 99) < 90) begin
            it.row_node = NODE_W'($urandom_range(0, NODES - 1));
            it.col_node = NODE_W'($urandom_range(0, NODES - 1));
         end
         pick = $urandom_range(0, 99);
         if (pick < 60)      it.edge_weight = WEIGHT_W'($urandom_range(1, 64));
         else if (pick < 75) it.edge_weight = '0;
         else if (pick < 90) it.edge_weight = WEIGHT_W'($urandom_range(65, 1000));
      end
      return it;
   endfunction

   function automatic logic [DIST_W-1:0] pick_route_limit();
      case ($urandom_range(0, 3))
         0: return DIST_W'($urandom_range(1, 100000));
         1: return DIST_W'($urandom_range(50, 1500));
         2: return LIMIT_ALL_ONES;
         default: return DIST_W'($urandom());
      endcase
   endfunction

   // offer one item, with an optional idle burst first, and wait for it to be taken
   task automatic send_item(input path_item_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= it.cmd;
      req_bus.row_node    <= it.row_node;
      req_bus.col_node    <= it.col_node;
      req_bus.edge_weight <= it.edge_weight;
      req_bus.start_node  <= it.start_node;
      req_bus.end_node    <= it.end_node;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      apply_item(it);
   endtask

   // stop offering and let every outstanding distance come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_route_limit(input logic [DIST_W-1:0] limit);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we      <= 1'b0;
      route_limit = limit;
      limits_written++;
   endtask

   // queries straight after reset, matrix empty, limit at its reset value
   task automatic test_empty_matrix();
      send_item(query_item(0, 0));
      send_item(query_item(3, 7));
   endtask

   // a small ring with an extreme weight, a self loop and loads outside the matrix
   task automatic test_directed_edges();
      send_item(load_item(0, 1, 4095));
      send_item(load_item(1, 2, 1));
      send_item(load_item(2, 3, 7));
      send_item(load_item(3, 0, 2));
      send_item(load_item(63, 0, 5));
      send_item(load_item(0, 63, 5));
      send_item(load_item(NODES - 1, NODES - 1, 1));
      send_item(load_item(NODES - 1, 0, 3));
      send_item(query_item(1, 0));
      send_item(query_item(0, 3));
      send_item(query_item(63, 0));
      send_item(query_item(0, 63));
   endtask

   // limit above the unreachable marker lets it through
   task automatic test_large_limit();
      set_route_limit(LIMIT_ALL_ONES);
      send_item(query_item(40, 2));
      send_item(query_item(0, 3));
      send_item(query_item(1, 5));
   endtask

   // limit of zero and one: everything reads as no route
   task automatic test_tiny_limit();
      set_route_limit('0);
      send_item(query_item(1, 0));
      send_item(query_item(2, 2));
      set_route_limit(DIST_W'(1));
      send_item(query_item(2, 2));
      send_item(query_item(1, 0));
   endtask

   task automatic test_top_limit();
      set_route_limit(INF_DIST);
      send_item(query_item(63, 63));
      send_item(query_item(0, 3));
   endtask

   // receiver holds off while queries and loads keep coming, so the block backs up
   task automatic test_output_backpressure();
      drain_results();
      rsp_hold_req = 1'b1;
      send_item(query_item(0, 3));
      send_item(query_item(NODES - 1, 2));
      send_item(load_item(4, 5, 9));
      send_item(load_item(5, 4, 11));
      send_item(query_item(1, 0));
   endtask

   // random graphs in phases, each with its own limit
   task automatic test_random_graphs();
      path_item_type it;
      int useful;
      int phase_items;
      useful = 0;
      while (useful < 450 || queries_sent < 56) begin
         set_route_limit(pick_route_limit());
         idle_on     = ($urandom_range(0, 3) != 0);
         phase_items = 0;
         while (phase_items < 90) begin
            it = random_graph_item();
            send_item(it);
            if (it.cmd == CMD_QUERY || (it.row_node < NODES && it.col_node < NODES))
               phase_items++;
         end
         useful += phase_items;
      end
   endtask

   // closing stretch at full rate on both sides
   task automatic test_steady_stream();
      set_route_limit(DIST_W'($urandom_range(200, 3000)));
      idle_on = 1'b0;
      repeat (60) send_item(random_graph_item());
   endtask

   // receiver: idle bursts, the long hold-off, and the distance check
   int stall_left;
   int hold_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_distances.size() == 0) begin
               $error("distance: no item expected, actual %0d", rsp_bus.distance);
               fail_count++;
            end else begin
               if (rsp_bus.distance !== expected_distances[0]) begin
                  $error("distance: expected %0d, actual %0d",
                         expected_distances[0], rsp_bus.distance);
                  fail_count++;
               end
               void'(expected_distances.pop_front());
               distances_checked++;
            end
         end
         if (rsp_hold_req) begin
            hold_left    = HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without progress", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = CMD_LOAD;
      req_bus.row_node    = '0;
      req_bus.col_node    = '0;
      req_bus.edge_weight = '0;
      req_bus.start_node  = '0;
      req_bus.end_node    = '0;
      rsp_bus.ready       = 1'b0;
      fail_count          = 0;
      loads_applied       = 0;
      loads_ignored       = 0;
      queries_sent        = 0;
      distances_checked   = 0;
      limits_written      = 0;
      rsp_hold_req        = 1'b0;
      idle_on             = 1'b1;
      route_limit         = LIMIT_RESET;
      for (int r = 0; r < NODES; r++)
         for (int c = 0; c < NODES; c++) weight_table[r][c] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_matrix();
      test_directed_edges();
      test_large_limit();
      test_tiny_limit();
      test_top_limit();
      test_output_backpressure();
      test_random_graphs();
      test_steady_stream();
      drain_results();

      $display("covered %0d edge loads (%0d outside the matrix) and %0d route queries",
               loads_applied, loads_ignored, queries_sent);
      $display("%0d distances compared across %0d no-route limit settings",
               distances_checked, limits_written);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
